// ----- rtl/ps2_set1_scancode_decoder_assert.svh -----
// Assertion macros for the PS/2 set 1 scan code decoder.
// Depends on a clock named aclk and an active-low reset named aresetn in scope.
`ifndef PS2_SET1_SCANCODE_DECODER_ASSERT_SVH
`define PS2_SET1_SCANCODE_DECODER_ASSERT_SVH

// Clocked check, disabled while reset is asserted
`define PS2S1_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked check that also holds during reset
`define PS2S1_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- rtl/ps2s1_pkg.sv -----
// Shared types, constants and key lookup functions for the set 1 decoder.
// No dependencies; imported by ps2s1_decode, ps2s1_out_stage and the top module.
package ps2s1_pkg;

    localparam logic [7:0] SCAN_PREFIX_EXT   = 8'hE0;
    localparam logic [7:0] SCAN_PREFIX_PAUSE = 8'hE1;

    localparam logic [6:0] KEY_UNKNOWN = 7'd0;
    localparam logic [6:0] KEY_LCTRL   = 7'd29;
    localparam logic [6:0] KEY_LSHIFT  = 7'd42;
    localparam logic [6:0] KEY_RSHIFT  = 7'd54;
    localparam logic [6:0] KEY_LALT    = 7'd55;
    localparam logic [6:0] KEY_CAPS    = 7'd57;
    localparam logic [6:0] KEY_RCTRL   = 7'd70;
    localparam logic [6:0] KEY_RALT    = 7'd71;

    typedef enum logic [1:0] {
        PFX_NONE   = 2'd0,
        PFX_EXT    = 2'd1,
        PFX_PAUSE1 = 2'd2,
        PFX_PAUSE2 = 2'd3
    } prefix_t;

    typedef struct packed {
        logic lshift;
        logic rshift;
        logic lctrl;
        logic rctrl;
        logic lalt;
        logic ralt;
        logic caps;
    } flags_t;

    typedef struct packed {
        logic [6:0] key_code;
        logic       released;
        logic [7:0] raw_byte;
        flags_t     flags;
    } event_t;

    function automatic logic [6:0] normal_key(input logic [6:0] c);
        unique case (c) inside
            [7'h01:7'h36]: return c;
            [7'h38:7'h44]: return c - 7'd1;
            7'h57:         return 7'd68;
            7'h58:         return 7'd69;
            default:       return KEY_UNKNOWN;
        endcase
    endfunction

    function automatic logic [6:0] extended_key(input logic [6:0] c);
        unique case (c)
            7'h1C:   return 7'd28;
            7'h1D:   return 7'd70;
            7'h35:   return 7'd53;
            7'h38:   return 7'd71;
            7'h47:   return 7'd72;
            7'h48:   return 7'd73;
            7'h49:   return 7'd74;
            7'h4B:   return 7'd75;
            7'h4D:   return 7'd76;
            7'h4F:   return 7'd77;
            7'h50:   return 7'd78;
            7'h51:   return 7'd79;
            7'h52:   return 7'd80;
            7'h53:   return 7'd81;
            default: return KEY_UNKNOWN;
        endcase
    endfunction

endpackage

// ----- rtl/ps2s1_in_stage.sv -----
// Input register for incoming scan bytes.
// Depends on nothing but the clock and reset.
module ps2s1_in_stage (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_scan_byte,
    input  logic       out_free,
    output logic       in_fire,
    output logic [7:0] in_byte
);

    logic       vld_reg;
    logic       vld_next;
    logic [7:0] byte_reg;
    logic       take;

    assign s_ready  = !vld_reg || out_free;
    assign take     = s_valid && s_ready;
    assign in_fire  = vld_reg && out_free;
    assign in_byte  = byte_reg;

    always_comb begin
        vld_next = vld_reg;
        if (take) begin
            vld_next = 1'b1;
        end else if (in_fire) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            byte_reg <= s_scan_byte;
        end
    end

endmodule

// ----- rtl/ps2s1_decode.sv -----
// Prefix state machine, modifier flags and key lookup.
// Depends on ps2s1_pkg and the assertion macro header.
`include "ps2_set1_scancode_decoder_assert.svh"

module ps2s1_decode (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_fire,
    input  logic [7:0]      in_byte,
    output logic            evt_valid,
    output ps2s1_pkg::event_t evt
);
    import ps2s1_pkg::*;

    prefix_t    prefix_reg;
    prefix_t    prefix_next;
    flags_t     flags_reg;
    flags_t     flags_next;
    logic [6:0] code;
    logic [6:0] key;
    logic       held;

    assign code = in_byte[6:0];
    assign held = !in_byte[7];
    assign key  = (prefix_reg == PFX_EXT) ? extended_key(code) : normal_key(code);

    always_comb begin
        prefix_next = prefix_reg;
        flags_next  = flags_reg;
        evt_valid   = 1'b0;
        if (in_fire) begin
            unique case (prefix_reg)
                PFX_NONE: begin
                    if (in_byte == SCAN_PREFIX_EXT) begin
                        prefix_next = PFX_EXT;
                    end else if (in_byte == SCAN_PREFIX_PAUSE) begin
                        prefix_next = PFX_PAUSE1;
                    end else begin
                        evt_valid = 1'b1;
                        unique case (key)
                            KEY_LSHIFT: flags_next.lshift = held;
                            KEY_RSHIFT: flags_next.rshift = held;
                            KEY_LCTRL:  flags_next.lctrl  = held;
                            KEY_LALT:   flags_next.lalt   = held;
                            KEY_CAPS:   flags_next.caps   = flags_reg.caps ^ held;
                            default:    ;
                        endcase
                    end
                end
                PFX_EXT: begin
                    // any byte ends the extended prefix, even another prefix
                    prefix_next = PFX_NONE;
                    evt_valid   = 1'b1;
                    unique case (key)
                        KEY_RCTRL: flags_next.rctrl = held;
                        KEY_RALT:  flags_next.ralt  = held;
                        default:   ;
                    endcase
                end
                PFX_PAUSE1: prefix_next = PFX_PAUSE2;
                PFX_PAUSE2: prefix_next = PFX_NONE;
                default:    prefix_next = PFX_NONE;
            endcase
        end
    end

    always_comb begin
        evt.key_code = key;
        evt.released = in_byte[7];
        evt.raw_byte = in_byte;
        evt.flags    = flags_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_reg <= PFX_NONE;
            flags_reg  <= '0;
        end else begin
            prefix_reg <= prefix_next;
            flags_reg  <= flags_next;
        end
    end

    `PS2S1_ASSERT_CLK(a_flags_hold_idle, !in_fire |=> $stable(flags_reg),
        "modifier flags changed without a transaction")
    `PS2S1_ASSERT_CLK(a_pause_swallow,
        in_fire && prefix_reg == PFX_PAUSE1 |-> !evt_valid ##1 prefix_reg == PFX_PAUSE2,
        "pause sequence byte not swallowed")
    `PS2S1_ASSERT_CLK(a_caps_toggle,
        in_fire && !(evt_valid && key == KEY_CAPS && held && prefix_reg == PFX_NONE)
            |=> flags_reg.caps == $past(flags_reg.caps),
        "caps lock changed without a caps press")

endmodule

// ----- rtl/ps2s1_out_stage.sv -----
// Result register holding one decoded key event for the output channel.
// Depends on ps2s1_pkg.
module ps2s1_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  ps2s1_pkg::event_t evt,
    output logic              out_free,
    output logic              m_valid,
    input  logic              m_ready,
    output ps2s1_pkg::event_t m_evt
);
    import ps2s1_pkg::*;

    logic   vld_reg;
    logic   vld_next;
    event_t evt_reg;

    assign out_free = !vld_reg || m_ready;
    assign m_valid  = vld_reg;
    assign m_evt    = evt_reg;

    always_comb begin
        vld_next = vld_reg;
        if (load) begin
            vld_next = 1'b1;
        end else if (m_ready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            evt_reg <= evt;
        end
    end

endmodule

// ----- rtl/ps2_set1_scancode_decoder.sv -----
// PS/2 scan code set 1 decoder: one byte per transaction, at most one key event.
// A byte that completes an event passes the input register, then the result register, before it shows on m_valid.
// Throughput: one byte per cycle while m_ready is high; set by the single decode pass
// between the input register and the result register.
// Reset (aresetn, synchronous): clears prefix state, all modifier flags and both stages.
// Depends on ps2s1_pkg, ps2s1_in_stage, ps2s1_decode and ps2s1_out_stage.
module ps2_set1_scancode_decoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_scan_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [6:0] m_key_code,
    output logic       m_released,
    output logic [7:0] m_raw_byte,
    output logic       m_left_shift_held,
    output logic       m_right_shift_held,
    output logic       m_left_ctrl_held,
    output logic       m_right_ctrl_held,
    output logic       m_left_alt_held,
    output logic       m_right_alt_held,
    output logic       m_caps_lock_on
);
    import ps2s1_pkg::*;

    logic       out_free;
    logic       in_fire;
    logic [7:0] in_byte;
    logic       evt_valid;
    event_t     evt;
    event_t     m_evt;

    ps2s1_in_stage u_in (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_scan_byte (s_scan_byte),
        .out_free    (out_free),
        .in_fire     (in_fire),
        .in_byte     (in_byte)
    );

    ps2s1_decode u_dec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .in_byte   (in_byte),
        .evt_valid (evt_valid),
        .evt       (evt)
    );

    ps2s1_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (evt_valid),
        .evt      (evt),
        .out_free (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_evt    (m_evt)
    );

    assign m_key_code         = m_evt.key_code;
    assign m_released         = m_evt.released;
    assign m_raw_byte         = m_evt.raw_byte;
    assign m_left_shift_held  = m_evt.flags.lshift;
    assign m_right_shift_held = m_evt.flags.rshift;
    assign m_left_ctrl_held   = m_evt.flags.lctrl;
    assign m_right_ctrl_held  = m_evt.flags.rctrl;
    assign m_left_alt_held    = m_evt.flags.lalt;
    assign m_right_alt_held   = m_evt.flags.ralt;
    assign m_caps_lock_on     = m_evt.flags.caps;

endmodule

// ----- tb/ps2_set1_scancode_decoder_test.sv -----
// Self-checking testbench for the PS/2 set 1 scan code decoder.
// Drives bytes over the valid/ready input channel, predicts each key event and
// checks every result field; depends on ps2s1_pkg and ps2_set1_scancode_decoder.
`timescale 1ns / 100ps

module ps2_set1_scancode_decoder_test;
    import ps2s1_pkg::*;

    typedef struct {
        logic [7:0] scan;
        bit         typed;
        event_t     want;
    } stim_row_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_scan_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [6:0] m_key_code;
    logic       m_released;
    logic [7:0] m_raw_byte;
    logic       m_left_shift_held;
    logic       m_right_shift_held;
    logic       m_left_ctrl_held;
    logic       m_right_ctrl_held;
    logic       m_left_alt_held;
    logic       m_right_alt_held;
    logic       m_caps_lock_on;

    // Decoder state as the predictor sees it
    prefix_t    pfx_state;
    flags_t     held_mods;

    event_t     pending_events[$];
    stim_row_t  directed_rows[$];

    int         n_errors = 0;
    int         n_bytes = 0;
    int         n_events = 0;
    int         n_ext_seqs = 0;
    int         n_pause_seqs = 0;
    bit         quiet_send = 1'b0;
    bit         quiet_recv = 1'b0;

    logic [6:0] mod_codes [5] = '{7'h2A, 7'h36, 7'h1D, 7'h38, 7'h3A};
    logic [6:0] ext_codes [14] = '{7'h1C, 7'h1D, 7'h35, 7'h38, 7'h47, 7'h48, 7'h49,
                                   7'h4B, 7'h4D, 7'h4F, 7'h50, 7'h51, 7'h52, 7'h53};

    ps2_set1_scancode_decoder dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_scan_byte        (s_scan_byte),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_key_code         (m_key_code),
        .m_released         (m_released),
        .m_raw_byte         (m_raw_byte),
        .m_left_shift_held  (m_left_shift_held),
        .m_right_shift_held (m_right_shift_held),
        .m_left_ctrl_held   (m_left_ctrl_held),
        .m_right_ctrl_held  (m_right_ctrl_held),
        .m_left_alt_held    (m_left_alt_held),
        .m_right_alt_held   (m_right_alt_held),
        .m_caps_lock_on     (m_caps_lock_on)
    );

    always #5 aclk = ~aclk;

    // Dense key number for a code from the plain table
    function automatic logic [6:0] plain_key_of(input logic [6:0] c);
        if (c == 7'h00)
            return KEY_UNKNOWN;
        if (c <= 7'h36)
            return c;
        if (c == 7'h37)
            return KEY_UNKNOWN;
        if (c <= 7'h44)
            return c - 7'd1;
        if (c == 7'h57)
            return 7'd68;
        if (c == 7'h58)
            return 7'd69;
        return KEY_UNKNOWN;
    endfunction

    // Dense key number for a code after the extended prefix
    function automatic logic [6:0] ext_key_of(input logic [6:0] c);
        case (c)
            7'h1C: return 7'd28;
            7'h35: return 7'd53;
            7'h1D: return 7'd70;
            7'h38: return 7'd71;
            7'h47: return 7'd72;
            7'h48: return 7'd73;
            7'h49: return 7'd74;
            7'h4B: return 7'd75;
            7'h4D: return 7'd76;
            7'h4F: return 7'd77;
            7'h50: return 7'd78;
            7'h51: return 7'd79;
            7'h52: return 7'd80;
            7'h53: return 7'd81;
            default: return KEY_UNKNOWN;
        endcase
    endfunction

    // Advance the predicted state by one byte; fires is set when a key event results
    task automatic decode_byte(input logic [7:0] b, output bit fires, output event_t ev);
        logic [6:0] k;
        logic       down;
        begin
            fires = 1'b0;
            ev = '0;
            k = KEY_UNKNOWN;
            down = ~b[7];
            case (pfx_state)
                PFX_NONE: begin
                    if (b == SCAN_PREFIX_EXT) begin
                        pfx_state = PFX_EXT;
                    end else if (b == SCAN_PREFIX_PAUSE) begin
                        pfx_state = PFX_PAUSE1;
                    end else begin
                        fires = 1'b1;
                        k = plain_key_of(b[6:0]);
                        case (k)
                            KEY_LSHIFT: held_mods.lshift = down;
                            KEY_RSHIFT: held_mods.rshift = down;
                            KEY_LCTRL:  held_mods.lctrl = down;
                            KEY_LALT:   held_mods.lalt = down;
                            KEY_CAPS:   if (down) held_mods.caps = ~held_mods.caps;
                            default: ;
                        endcase
                    end
                end
                PFX_EXT: begin
                    pfx_state = PFX_NONE;
                    fires = 1'b1;
                    k = ext_key_of(b[6:0]);
                    if (k == KEY_RCTRL)
                        held_mods.rctrl = down;
                    else if (k == KEY_RALT)
                        held_mods.ralt = down;
                end
                PFX_PAUSE1: pfx_state = PFX_PAUSE2;
                default:    pfx_state = PFX_NONE;
            endcase
            if (fires) begin
                ev.key_code = k;
                ev.released = b[7];
                ev.raw_byte = b;
                ev.flags = held_mods;
            end
        end
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_byte(input logic [7:0] b, input bit typed, input event_t want);
        int     gap;
        bit     fires;
        event_t ev;
        begin
            gap = quiet_send ? 0 : $urandom_range(0, 11);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            s_valid <= 1'b1;
            s_scan_byte <= b;
            do @(posedge aclk); while (s_ready !== 1'b1);
            n_bytes++;
            if (n_bytes % 50 == 0)
                quiet_send = ($urandom_range(0, 2) == 0);
            decode_byte(b, fires, ev);
            if (fires)
                pending_events.push_back(typed ? want : ev);
            @(negedge aclk);
        end
    endtask

    task automatic add_row(input logic [7:0] scan);
        stim_row_t r;
        begin
            r.scan = scan;
            r.typed = 1'b0;
            r.want = '0;
            directed_rows.push_back(r);
        end
    endtask

    // Row whose event is known outright: all flags still clear
    task automatic add_typed_row(input logic [7:0] scan, input logic [6:0] key,
                                 input logic rel);
        stim_row_t r;
        begin
            r.scan = scan;
            r.typed = 1'b1;
            r.want = '0;
            r.want.key_code = key;
            r.want.released = rel;
            r.want.raw_byte = scan;
            directed_rows.push_back(r);
        end
    endtask

    task automatic send_plain(input logic [7:0] b);
        send_byte(b, 1'b0, '0);
    endtask

    // One random sequence: mostly well-formed key codes, some noise
    task automatic send_random_seq();
        int         pick;
        logic [6:0] c;
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                if ($urandom_range(0, 2) == 0)
                    c = mod_codes[3'($urandom_range(0, 4))];
                else
                    c = 7'($urandom_range(0, 127));
                send_plain({1'($urandom_range(0, 1)), c});
            end else if (pick < 65) begin
                n_ext_seqs++;
                send_plain(SCAN_PREFIX_EXT);
                if ($urandom_range(0, 9) == 0)
                    send_plain($urandom_range(0, 1) ? SCAN_PREFIX_EXT : SCAN_PREFIX_PAUSE);
                else begin
                    if ($urandom_range(0, 4) < 3)
                        c = ext_codes[4'($urandom_range(0, 13))];
                    else
                        c = 7'($urandom_range(0, 127));
                    send_plain({1'($urandom_range(0, 1)), c});
                end
            end else if (pick < 75) begin
                n_pause_seqs++;
                send_plain(SCAN_PREFIX_PAUSE);
                send_plain(8'($urandom_range(0, 255)));
                send_plain(8'($urandom_range(0, 255)));
            end else begin
                send_plain(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            n_errors++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Compare each accepted result against the oldest prediction
    always @(posedge aclk) begin : result_check
        event_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (pending_events.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected key event: expected none, got key %0d raw %02h",
                         $time, m_key_code, m_raw_byte);
            end else begin
                want = pending_events.pop_front();
                n_events++;
                check_field("key_code", int'(want.key_code), int'(m_key_code));
                check_field("released", int'(want.released), int'(m_released));
                check_field("raw_byte", int'(want.raw_byte), int'(m_raw_byte));
                check_field("left_shift_held", int'(want.flags.lshift),
                            int'(m_left_shift_held));
                check_field("right_shift_held", int'(want.flags.rshift),
                            int'(m_right_shift_held));
                check_field("left_ctrl_held", int'(want.flags.lctrl),
                            int'(m_left_ctrl_held));
                check_field("right_ctrl_held", int'(want.flags.rctrl),
                            int'(m_right_ctrl_held));
                check_field("left_alt_held", int'(want.flags.lalt),
                            int'(m_left_alt_held));
                check_field("right_alt_held", int'(want.flags.ralt),
                            int'(m_right_alt_held));
                check_field("caps_lock_on", int'(want.flags.caps), int'(m_caps_lock_on));
            end
        end
    end

    // Result side: stall a random number of cycles before each transaction
    initial begin : result_drain
        int stall;
        int seen;
        seen = 0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (seen % 40 == 0)
                quiet_recv = ($urandom_range(0, 2) == 0);
            stall = quiet_recv ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            seen++;
            @(negedge aclk);
        end
    end

    initial begin : watchdog
        #2_000_000;
        $display("ps2_set1_scancode_decoder regression: fail");
        $finish;
    end

    initial begin : stimulus
        bit paused;
        paused = 1'b0;
        pfx_state = PFX_NONE;
        held_mods = '0;

        // Extremes and prefix corner cases, all while no modifier is held
        add_typed_row(8'h00, KEY_UNKNOWN, 1'b0);
        add_typed_row(8'hFF, KEY_UNKNOWN, 1'b1);
        add_typed_row(8'h01, 7'd1, 1'b0);
        add_row(SCAN_PREFIX_EXT);
        add_typed_row(SCAN_PREFIX_EXT, KEY_UNKNOWN, 1'b1);
        add_row(SCAN_PREFIX_EXT);
        add_typed_row(SCAN_PREFIX_PAUSE, KEY_UNKNOWN, 1'b1);
        // Pause sequence swallows prefixes too
        add_row(SCAN_PREFIX_PAUSE);
        add_row(SCAN_PREFIX_EXT);
        add_row(SCAN_PREFIX_PAUSE);
        // Modifiers, caps toggle and release, extended modifiers
        add_row(8'h2A);
        add_row(8'h36);
        add_row(8'h1D);
        add_row(8'h38);
        add_row(8'h3A);
        add_row(8'hBA);
        add_row(SCAN_PREFIX_EXT);
        add_row(8'h1D);
        add_row(SCAN_PREFIX_EXT);
        add_row(8'h38);
        // Extended shift code is an unknown key
        add_row(SCAN_PREFIX_EXT);
        add_row(8'h2A);
        add_row(8'h58);
        add_row(8'hAA);
        add_row(SCAN_PREFIX_EXT);
        add_row(8'h9D);

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i])
            send_byte(directed_rows[i].scan, directed_rows[i].typed, directed_rows[i].want);

        while (n_bytes < 850) begin
            send_random_seq();
            if (!paused && n_bytes >= 400) begin
                // Hold the input off until the result side has caught up
                paused = 1'b1;
                s_valid <= 1'b0;
                do @(negedge aclk); while (pending_events.size() != 0);
            end
        end

        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_events.size() != 0);
        repeat (20) @(negedge aclk);

        $display("Sent %0d bytes (%0d extended, %0d pause sequences); checked %0d key events.",
                 n_bytes, n_ext_seqs, n_pause_seqs, n_events);
        $display("Mismatches found: %0d", n_errors);
        if (n_errors == 0 && pending_events.size() == 0) begin
            $display("ps2_set1_scancode_decoder regression: pass");
        end else begin
            $display("ps2_set1_scancode_decoder regression: fail");
        end
        $finish;
    end

endmodule
